FILE: hdl/bwl_pkg.sv
// shared types, constants and codes for the bounded-waiting lock arbiter
package bwl_pkg;

	localparam int MAX_THREADS = 16;
	localparam int TID_W       = 4;
	localparam int CNT_W       = 5;

	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_THREADS);

	typedef enum logic [1:0] {
		ERR_NONE         = 2'd0,
		ERR_FREE_RELEASE = 2'd1,
		ERR_RANGE        = 2'd2
	} err_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} bwl_cmd_t;

endpackage

FILE: hdl/bounded_waiting_lock_arbiter.sv
// top level of the bounded-waiting lock arbiter
// A request or release beat is taken when start is high and busy is low. Each
// beat first captures the command, then does the round-robin scan of the 16-bit
// waiting mask and the state update. The result appears on the output ports
// with done high for exactly one cycle, the cycle after the scan; the receiver
// cannot stall, so it must take the result then. busy is high only during the
// scan cycle, so a new beat can be started in the same cycle that done is shown.
// active_threads is written through cfg_we and cfg_wdata; the user must write it
// only while no beat is in flight, as the block does not enforce this. It resets
// to 16; zero acts as one and values above 16 act as 16.
module bounded_waiting_lock_arbiter import bwl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             req_type,
	input  logic [TID_W-1:0] thread_id,
	output logic             granted_now,
	output logic             handoff_valid,
	output logic [TID_W-1:0] handoff_thread,
	output logic             lock_busy,
	output logic [1:0]       error_code
);

	bwl_cmd_t cmd;

	bwl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	bwl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req_type       (req_type),
		.thread_id      (thread_id),
		.granted_now    (granted_now),
		.handoff_valid  (handoff_valid),
		.handoff_thread (handoff_thread),
		.lock_busy      (lock_busy),
		.error_code     (error_code)
	);

	// an accepted beat enters the execute state, then gives its registered result strobe
	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done) ##1 done)
		else $error("result strobe not two cycles after accept");

	// a grant or a handoff always leaves the lock held
	a_held_after_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (granted_now || handoff_valid)) |-> lock_busy)
		else $error("lock free after grant or handoff");

	// an error beat never grants nor hands off
	a_err_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (error_code != ERR_NONE)) |-> (!granted_now && !handoff_valid))
		else $error("error beat granted the lock");

	// grant and handoff are exclusive
	a_grant_handoff_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(granted_now && handoff_valid))
		else $error("grant and handoff in the same beat");

endmodule

FILE: hdl/bwl_ctrl.sv
// controller state machine: capture, execute, result strobe
module bwl_ctrl import bwl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output bwl_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.exec;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		busy      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				busy      = 1'b1;
				cmd.exec  = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule

FILE: hdl/bwl_dp.sv
// datapath: lock state, waiting mask, round-robin scan and result registers
module bwl_dp import bwl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  bwl_cmd_t         cmd,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             req_type,
	input  logic [TID_W-1:0] thread_id,
	output logic             granted_now,
	output logic             handoff_valid,
	output logic [TID_W-1:0] handoff_thread,
	output logic             lock_busy,
	output logic [1:0]       error_code
);

	logic [CNT_W-1:0]       active_threads_q;
	logic                   req_type_q;
	logic [TID_W-1:0]       tid_q;
	logic                   lock_held_q;
	logic [MAX_THREADS-1:0] waiting_q;

	logic                   granted_q;
	logic                   hvalid_q;
	logic [TID_W-1:0]       hthread_q;
	err_t                   err_q;

	logic [CNT_W-1:0]       n_eff;
	logic [MAX_THREADS-1:0] range_mask;
	logic [MAX_THREADS-1:0] above_mask;
	logic [MAX_THREADS-1:0] cand;
	logic [MAX_THREADS-1:0] cand_hi;
	logic [TID_W-1:0]       sel;
	logic                   found;

	logic                   lock_nxt;
	logic [MAX_THREADS-1:0] waiting_nxt;
	logic                   granted_nxt;
	logic                   hvalid_nxt;
	logic [TID_W-1:0]       hthread_nxt;
	err_t                   err_nxt;

	function automatic logic [TID_W-1:0] lowest_set(input logic [MAX_THREADS-1:0] v);
		logic [TID_W-1:0] idx;
		idx = '0;
		for (int i = MAX_THREADS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = TID_W'(i);
			end
		end
		return idx;
	endfunction

	// effective count: zero reads as one, clipped at the thread limit
	always_comb begin
		if (active_threads_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (active_threads_q > CNT_W'(MAX_THREADS)) begin
			n_eff = CNT_W'(MAX_THREADS);
		end else begin
			n_eff = active_threads_q;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_THREADS; i++) begin
			range_mask[i] = CNT_W'(i) < n_eff;
			above_mask[i] = TID_W'(i) > tid_q;
		end
	end

	// scan order: threads above the releaser first, then wrap to the lowest
	assign cand    = waiting_q & range_mask & ~(MAX_THREADS'(1) << tid_q);
	assign cand_hi = cand & above_mask;
	assign found   = |cand;
	assign sel     = (|cand_hi) ? lowest_set(cand_hi) : lowest_set(cand);

	always_comb begin
		lock_nxt    = lock_held_q;
		waiting_nxt = waiting_q;
		granted_nxt = 1'b0;
		hvalid_nxt  = 1'b0;
		hthread_nxt = '0;
		err_nxt     = ERR_NONE;
		if ({1'b0, tid_q} >= n_eff) begin
			err_nxt = ERR_RANGE;
		end else if (req_type_q == REQ_ACQUIRE) begin
			if (!lock_held_q) begin
				lock_nxt    = 1'b1;
				granted_nxt = 1'b1;
			end else begin
				waiting_nxt[tid_q] = 1'b1;
			end
		end else if (!lock_held_q) begin
			err_nxt = ERR_FREE_RELEASE;
		end else if (found) begin
			waiting_nxt[sel] = 1'b0;
			hvalid_nxt       = 1'b1;
			hthread_nxt      = sel;
		end else begin
			lock_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_threads_q <= CNT_RESET;
			lock_held_q      <= 1'b0;
			waiting_q        <= '0;
		end else begin
			if (cfg_we) begin
				active_threads_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				lock_held_q <= lock_nxt;
				waiting_q   <= waiting_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			tid_q      <= thread_id;
		end
		if (cmd.exec) begin
			granted_q <= granted_nxt;
			hvalid_q  <= hvalid_nxt;
			hthread_q <= hthread_nxt;
			err_q     <= err_nxt;
		end
	end

	assign granted_now    = granted_q;
	assign handoff_valid  = hvalid_q;
	assign handoff_thread = hthread_q;
	assign lock_busy      = lock_held_q;
	assign error_code     = err_q;

endmodule
